>>> rtl/box_mean_filter_5x5_macros.svh
// assertion helpers shared by the filter modules
`ifndef BOX_MEAN_FILTER_5X5_MACROS_SVH
`define BOX_MEAN_FILTER_5X5_MACROS_SVH

// same-cycle implication, checked outside reset
`define BMF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bmf_pkg.sv
`default_nettype none

package bmf_pkg;

    localparam int KERNEL_SIZE  = 5;
    localparam int BORDER       = 2;
    localparam int AREA         = 25;
    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 2048;

    localparam int PIX_W        = 8;
    localparam int CFG_W        = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int ROW_W        = 11;
    localparam int LS_W         = PIX_W * (KERNEL_SIZE - 1);
    localparam int COLSUM_W     = 11;
    localparam int SUM_W        = 13;

    // floor(s / 25) == (s * 5243) >> 17 for every s up to 25 * 255
    localparam int RECIP        = 5243;
    localparam int RECIP_SHIFT  = 17;
    localparam int PROD_W       = 26;

    localparam int WIDTH_RESET  = 2048;
    localparam int HEIGHT_RESET = 2048;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // window position of one accepted pixel
    typedef struct packed {
        logic emit;
        logic last;
    } t_pos;

    // stage load strobes for the datapath
    typedef struct packed {
        logic load_b;
        logic load_c;
        logic load_d;
    } t_stage_en;

endpackage

`default_nettype wire

>>> rtl/bmf_ctrl.sv
`default_nettype none
`include "box_mean_filter_5x5_macros.svh"

module bmf_ctrl #(
    parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bmf_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_accept,
    output logic      [AW-1:0]                  o_col,
    output bmf_pkg::t_pos                       o_pos
);
    import bmf_pkg::*;

    localparam int XW        = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int RST_W     = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int RST_H     = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;
    localparam int FULL_AT   = KERNEL_SIZE - 1;

    logic [AW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [AW-1:0]    r_last_col, n_last_col;
    logic [ROW_W-1:0] r_last_row, n_last_row;
    logic [XW-1:0]    cfg_ext;
    logic             cfg_hit;

    assign cfg_ext = XW'(i_cfg_data);
    assign cfg_hit = i_cfg_we &&
                     (i_cfg_index == REG_LINE_WIDTH || i_cfg_index == REG_FRAME_HEIGHT);

    // saturate the written size and keep the last index
    always_comb begin
        n_last_col = r_last_col;
        n_last_row = r_last_row;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LINE_WIDTH: begin
                    if (cfg_ext < XW'(KERNEL_SIZE)) begin
                        n_last_col = AW'(KERNEL_SIZE - 1);
                    end else if (cfg_ext > XW'(MAX_WIDTH)) begin
                        n_last_col = AW'(MAX_WIDTH - 1);
                    end else begin
                        n_last_col = AW'(cfg_ext - XW'(1));
                    end
                end
                REG_FRAME_HEIGHT: begin
                    if (i_cfg_data < CFG_W'(KERNEL_SIZE)) begin
                        n_last_row = ROW_W'(KERNEL_SIZE - 1);
                    end else if (i_cfg_data > CFG_W'(MAX_HEIGHT)) begin
                        n_last_row = ROW_W'(MAX_HEIGHT - 1);
                    end else begin
                        n_last_row = ROW_W'(i_cfg_data - CFG_W'(1));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (i_accept) begin
            if (r_col == r_last_col) begin
                n_col = '0;
                n_row = (r_row == r_last_row) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_last_col <= AW'(RST_W - 1);
            r_last_row <= ROW_W'(RST_H - 1);
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
        end
    end

    assign o_col     = r_col;
    assign o_pos.emit = (r_row >= ROW_W'(FULL_AT)) && (r_col >= AW'(FULL_AT));
    assign o_pos.last = (r_row == r_last_row) && (r_col == r_last_col);

    `BMF_ASSERT_NOW(a_col_in_row, i_clk, i_rst_n, 1'b1, r_col <= r_last_col, "column past row end")
    `BMF_ASSERT_NEXT(a_wrap_frame, i_clk, i_rst_n, i_accept && o_pos.last, r_col == '0 && r_row == '0, "no frame wrap")
    `BMF_ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n, cfg_hit, r_col == '0 && r_row == '0, "no restart on write")

endmodule

`default_nettype wire

>>> rtl/bmf_line_buf.sv
`default_nettype none

module bmf_line_buf #(
    parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rd_en,
    input  wire logic [AW-1:0]              i_rd_addr,
    input  wire logic                       i_wr_en,
    input  wire logic [AW-1:0]              i_wr_addr,
    input  wire logic [bmf_pkg::PIX_W-1:0]  i_wr_pix,
    output logic      [bmf_pkg::LS_W-1:0]   o_rd_data
);
    import bmf_pkg::*;

    logic [LS_W-1:0] r_mem [MAX_WIDTH];
    logic [LS_W-1:0] r_rd_data;

    // write back shifts the column up one row, newest pixel at the bottom
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {r_rd_data[LS_W-PIX_W-1:0], i_wr_pix};
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/bmf_window.sv
`default_nettype none

module bmf_window (
    input  wire logic                       i_clk,
    input  wire bmf_pkg::t_stage_en         i_en,
    input  wire logic [bmf_pkg::LS_W-1:0]   i_rd_data,
    input  wire logic [bmf_pkg::PIX_W-1:0]  i_pix,
    output logic      [bmf_pkg::PIX_W-1:0]  o_mean
);
    import bmf_pkg::*;

    localparam int HIST = KERNEL_SIZE - 1;

    logic [COLSUM_W-1:0] r_b_cs, n_b_cs;
    logic [COLSUM_W-1:0] r_hist [HIST];
    logic [SUM_W-1:0]    r_c_sum, n_c_sum;
    logic [PROD_W-1:0]   prod;
    logic [PIX_W-1:0]    r_mean;

    // vertical sum of the five pixels of the new column
    always_comb begin
        n_b_cs = COLSUM_W'(i_pix);
        for (int k = 0; k < HIST; k++) begin
            n_b_cs = n_b_cs + COLSUM_W'(i_rd_data[k*PIX_W +: PIX_W]);
        end
    end

    // horizontal sum over the new column and four older ones
    always_comb begin
        n_c_sum = SUM_W'(r_b_cs);
        for (int k = 0; k < HIST; k++) begin
            n_c_sum = n_c_sum + SUM_W'(r_hist[k]);
        end
    end

    assign prod = PROD_W'(r_c_sum) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.load_b) begin
            r_b_cs <= n_b_cs;
        end
        if (i_en.load_c) begin
            r_c_sum <= n_c_sum;
            for (int k = 0; k < HIST - 1; k++) begin
                r_hist[k] <= r_hist[k+1];
            end
            r_hist[HIST-1] <= r_b_cs;
        end
        if (i_en.load_d) begin
            r_mean <= prod[RECIP_SHIFT +: PIX_W];
        end
    end

    assign o_mean = r_mean;

endmodule

`default_nettype wire

>>> rtl/box_mean_filter_5x5.sv
// channel   dir   signals                                     moves
// pixel     in    i_in_valid / o_in_stall / i_pixel_in        one padded pixel
// result    out   o_out_valid / i_out_stall / o_mean_out,     one 5x5 mean
//                 o_frame_end
// config    in    i_cfg_valid / o_cfg_ready / i_cfg_index,    one register write
//                 i_cfg_data
//
// one pixel request per clock sustained without output stall; results pass stages a, b, c and d
// the rate is set by the line store, one read and one write port per cycle
// synchronous active-low reset clears counters and stage valids, sizes go to 2048
// the line store needs no clearing pass, rows are rewritten before they are summed
// each stage moves when the next one is empty or moving, so bubbles close up
// under an output stall and input stall rises only when all stages are full
`default_nettype none
`include "box_mean_filter_5x5_macros.svh"

module box_mean_filter_5x5 #(
    parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // pixel request channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [bmf_pkg::PIX_W-1:0]      i_pixel_in,
    // result request channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [bmf_pkg::PIX_W-1:0]      o_mean_out,
    output logic                                o_frame_end,
    // configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bmf_pkg::CFG_W-1:0]      i_cfg_data
);
    import bmf_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    // stage a: pixel plus line store read, b: column sum,
    // c: window sum, d: divided result at the outputs
    logic            r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic [PIX_W-1:0] r_a_pix;
    logic [AW-1:0]   r_a_col;
    t_pos            r_a_pos, r_b_pos;
    logic            r_c_last, r_d_last;

    logic            rdy_a, rdy_b, rdy_c, rdy_d;
    logic            adv_a, adv_b, adv_c;
    logic            accept, cfg_we;
    logic [AW-1:0]   cur_col;
    t_pos            cur_pos;
    logic [LS_W-1:0] rd_data;
    t_stage_en       stage_en;

    // ready ripples back from the output register
    assign rdy_d  = !r_d_valid || !i_out_stall;
    assign adv_c  = r_c_valid && rdy_d;
    assign rdy_c  = !r_c_valid || rdy_d;
    assign adv_b  = r_b_valid && rdy_c;
    assign rdy_b  = !r_b_valid || rdy_c;
    assign adv_a  = r_a_valid && rdy_b;
    assign rdy_a  = !r_a_valid || rdy_b;
    assign accept = i_in_valid && rdy_a;

    assign o_in_stall  = !rdy_a;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    // window shifts for every pixel, only full windows reach stage c
    assign stage_en.load_b = adv_a;
    assign stage_en.load_c = adv_b;
    assign stage_en.load_d = adv_c;

    bmf_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .o_col       (cur_col),
        .o_pos       (cur_pos)
    );

    // read at accept, write back as the pixel leaves stage a
    bmf_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (cur_col),
        .i_wr_en   (adv_a),
        .i_wr_addr (r_a_col),
        .i_wr_pix  (r_a_pix),
        .o_rd_data (rd_data)
    );

    bmf_window u_window (
        .i_clk     (i_clk),
        .i_en      (stage_en),
        .i_rd_data (rd_data),
        .i_pix     (r_a_pix),
        .o_mean    (o_mean_out)
    );

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (adv_a) begin
                r_a_valid <= 1'b0;
            end
            if (adv_a) begin
                r_b_valid <= 1'b1;
            end else if (adv_b) begin
                r_b_valid <= 1'b0;
            end
            if (adv_b) begin
                r_c_valid <= r_b_pos.emit;
            end else if (adv_c) begin
                r_c_valid <= 1'b0;
            end
            if (adv_c) begin
                r_d_valid <= 1'b1;
            end else if (r_d_valid && !i_out_stall) begin
                r_d_valid <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pix <= i_pixel_in;
            r_a_col <= cur_col;
            r_a_pos <= cur_pos;
        end
        if (adv_a) begin
            r_b_pos <= r_a_pos;
        end
        if (adv_b) begin
            r_c_last <= r_b_pos.last;
        end
        if (adv_c) begin
            r_d_last <= r_c_last;
        end
    end

    assign o_out_valid = r_d_valid;
    assign o_frame_end = r_d_last;

    `BMF_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_in_stall, r_a_valid && r_b_valid && r_c_valid && r_d_valid, "stall with a free stage")
    `BMF_ASSERT_NEXT(a_c_to_d, i_clk, i_rst_n, r_c_valid && !r_d_valid, r_d_valid, "window sum not moved out")
    `BMF_ASSERT_NEXT(a_a_to_b, i_clk, i_rst_n, r_a_valid && !r_b_valid, r_b_valid, "pixel not moved to column stage")

endmodule

`default_nettype wire

>>> verif/box_mean_filter_5x5_checker.sv
`timescale 1ns / 100ps

module box_mean_filter_5x5_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [bmf_pkg::PIX_W-1:0]           i_pixel_in,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [bmf_pkg::PIX_W-1:0]           i_mean_out,
    input  logic                                i_frame_end,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]           i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import bmf_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic             frame_end;
    } t_mean_result;

    logic [CFG_W-1:0]             width_reg;
    logic [CFG_W-1:0]             height_reg;
    logic [LS_W-1:0]              row_history [MAX_WIDTH];
    logic [KERNEL_SIZE*PIX_W-1:0] window_cols [KERNEL_SIZE];
    int unsigned                  col_pos;
    int unsigned                  row_pos;
    t_mean_result                 expected_means [$];

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < KERNEL_SIZE) return KERNEL_SIZE;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    // one pixel into the window, queue the mean when the window is full
    task automatic predict_mean(input logic [PIX_W-1:0] pix);
        int unsigned                  w;
        int unsigned                  h;
        int unsigned                  c;
        int unsigned                  r;
        int unsigned                  sum;
        logic [KERNEL_SIZE*PIX_W-1:0] column;
        t_mean_result                 res;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        column = {row_history[c], pix};
        row_history[c] = column[LS_W-1:0];
        for (int k = 0; k < KERNEL_SIZE - 1; k++) window_cols[k] = window_cols[k + 1];
        window_cols[KERNEL_SIZE-1] = column;
        if (r >= KERNEL_SIZE - 1 && c >= KERNEL_SIZE - 1) begin
            sum = 0;
            for (int k = 0; k < KERNEL_SIZE; k++)
                for (int b = 0; b < KERNEL_SIZE; b++)
                    sum += 32'(window_cols[k][b*PIX_W +: PIX_W]);
            res.mean = PIX_W'(sum / AREA);
            res.frame_end = (r == h - 1) && (c == w - 1);
            expected_means.insert(expected_means.size(), res);
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    task automatic note_failure(input string what, input t_mean_result want,
                                input t_mean_result got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t %s: expected mean %0d end %0d, got mean %0d end %0d", $time, what,
                     want.mean, want.frame_end, got.mean, got.frame_end);
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin : watch
        t_mean_result want;
        t_mean_result got;
        if (!i_rst_n) begin
            width_reg = CFG_W'(WIDTH_RESET);
            height_reg = CFG_W'(HEIGHT_RESET);
            col_pos = 0;
            row_pos = 0;
            for (int k = 0; k < KERNEL_SIZE; k++) window_cols[k] = '0;
            expected_means.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.mean = i_mean_out;
                got.frame_end = i_frame_end;
                if (expected_means.size() == 0) begin
                    note_failure("unexpected result", '0, got);
                end else begin
                    want = expected_means.pop_front();
                    if (got.mean !== want.mean || got.frame_end !== want.frame_end)
                        note_failure("result mismatch", want, got);
                end
            end
            // a size write restarts the frame, spare indexes change nothing
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_LINE_WIDTH: begin
                        width_reg = i_cfg_data;
                        col_pos = 0;
                        row_pos = 0;
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg = i_cfg_data;
                        col_pos = 0;
                        row_pos = 0;
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_mean(i_pixel_in);
        end
        o_pending = expected_means.size();
    end

endmodule

>>> verif/box_mean_filter_5x5_tb.sv
`timescale 1ns / 100ps

module box_mean_filter_5x5_tb;
    import bmf_pkg::*;

    // receiver hold-off used to fill the pipe and stall the sender
    localparam int HOLD_CYCLES    = 300;
    // quiet time before a register write, lets the pipe drain
    localparam int SETTLE_CYCLES  = 12;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 180;
    // pixels sent at each saturated size
    localparam int SAT_ITEMS      = 120;

    // indexes past the two size registers, writes there change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // pixel content of a frame
    typedef enum logic [1:0] {
        FILL_NOISE,
        FILL_FLAT,
        FILL_EXTREME
    } t_fill;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [PIX_W-1:0]      i_pixel_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [PIX_W-1:0]      o_mean_out;
    logic                  o_frame_end;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;

    int   fail_count;
    int   pending;
    int   idle_pct;
    int   stall_pct;
    logic hold_req;

    // idling per random phase: none, sender, receiver, both
    int   idle_plan  [4] = '{0, 88, 0, 34};
    int   stall_plan [4] = '{0, 0, 88, 34};

    box_mean_filter_5x5 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_mean_out  (o_mean_out),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predicts every mean and compares the result requests
    box_mean_filter_5x5_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_pixel_in   (i_pixel_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_mean_out   (o_mean_out),
        .i_frame_end  (o_frame_end),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver side: random stall, or one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_stall = ($urandom_range(99) < stall_pct);
            end
        end
    end

    // no request accepted on any channel for too long means a hang
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("box_mean_filter_5x5 verification failed");
        $finish;
    end

    // one pixel request, with a random gap in front of it
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            i_pixel_in = PIX_W'($urandom);
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_pixel_in = pix;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_pixels(input int count, input t_fill fill,
                               input logic [PIX_W-1:0] flat_val);
        logic [PIX_W-1:0] pix;
        for (int n = 0; n < count; n++) begin
            case (fill)
                FILL_NOISE: pix = PIX_W'($urandom);
                FILL_FLAT:  pix = flat_val;
                default:    pix = $urandom_range(1) ? '1 : '0;
            endcase
            send_pixel(pix);
        end
    endtask

    // sender quiet, every expected mean back, pipe drained
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int               frame_len;
        int               cut;
        int               nframes;
        int               sent;
        bit               pressure_done;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;
        t_fill            fill;
        logic [PIX_W-1:0] flat_val;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_pixel_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_LINE_WIDTH;
        i_cfg_data = '0;
        hold_req = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        pressure_done = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // a few pixels at the reset sizes, then a write drops the partial frame
        send_pixels(7, FILL_NOISE, '0);
        wait_idle();
        // sizes below the minimum saturate to a 5x5 frame
        write_reg(REG_LINE_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
        // single window, full scale, last of frame
        send_pixels(KERNEL_SIZE * KERNEL_SIZE, FILL_FLAT, '1);

        // random phases: small frames, several sizes, cuts and spare writes
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = idle_plan[ph];
            stall_pct = stall_plan[ph];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                w_val = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(4)) :
                                                   CFG_W'($urandom_range(5, 12));
                h_val = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(4)) :
                                                   CFG_W'($urandom_range(5, 9));
                frame_len = ((w_val < KERNEL_SIZE) ? KERNEL_SIZE : w_val) *
                            ((h_val < KERNEL_SIZE) ? KERNEL_SIZE : h_val);
                fill = t_fill'($urandom_range(2));
                case ($urandom_range(2))
                    0:       flat_val = '0;
                    1:       flat_val = '1;
                    default: flat_val = PIX_W'($urandom);
                endcase
                wait_idle();
                if ($urandom_range(1)) begin
                    write_reg(REG_LINE_WIDTH, w_val);
                    write_reg(REG_FRAME_HEIGHT, h_val);
                end else begin
                    write_reg(REG_FRAME_HEIGHT, h_val);
                    write_reg(REG_LINE_WIDTH, w_val);
                end
                // long receiver hold while pixels keep coming
                if (ph == 0 && !pressure_done) begin
                    hold_req = 1'b1;
                    pressure_done = 1'b1;
                end
                nframes = $urandom_range(1, 2);
                for (int f = 0; f < nframes; f++) begin
                    if ($urandom_range(3) == 0) begin
                        // spare register written mid-frame, frame carries on
                        cut = $urandom_range(1, frame_len - 1);
                        send_pixels(cut, fill, flat_val);
                        wait_idle();
                        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                                  CFG_W'($urandom));
                        send_pixels(frame_len - cut, fill, flat_val);
                    end else begin
                        send_pixels(frame_len, fill, flat_val);
                    end
                end
                sent += nframes * frame_len;
                // trailing partial frame, dropped by the next size write
                if ($urandom_range(2) == 0) begin
                    cut = $urandom_range(1, frame_len - 1);
                    send_pixels(cut, fill, flat_val);
                    sent += cut;
                end
            end
        end

        // widest line, saturated from all ones: early rows only, no full window
        idle_pct = 0;
        stall_pct = 0;
        wait_idle();
        write_reg(REG_LINE_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, '0);
        send_pixels(SAT_ITEMS, FILL_NOISE, '0);
        wait_idle();
        // narrow line, tallest frame saturated from all ones, its first rows
        write_reg(REG_LINE_WIDTH, CFG_W'(KERNEL_SIZE));
        write_reg(REG_FRAME_HEIGHT, '1);
        send_pixels(SAT_ITEMS, FILL_NOISE, '0);

        // drain and let any stray result show up
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("box_mean_filter_5x5 verification clean");
        else
            $display("box_mean_filter_5x5 verification failed");
        $finish;
    end

endmodule
